>>> sv/text_console_writer_assert.svh
// ----------------------------------------------------------------------------
// text_console_writer_assert.svh
// Assertion macros shared by the console writer modules.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("text console writer: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("text console writer: assertion failed");

`endif

>>> sv/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Types, codes and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int TCW_MAX_COLS    = 80;
  localparam int TCW_MAX_ROWS    = 25;
  localparam int TCW_QUEUE_DEPTH = 2;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] REG_FG     = 2'd0;
  localparam logic [1:0] REG_BG     = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  localparam logic [7:0]  NL_CODE     = 8'd10;
  localparam logic [3:0]  FG_RESET    = 4'd15;
  localparam logic [3:0]  BG_RESET    = 4'd0;
  localparam logic [6:0]  WIDTH_RESET = 7'd80;
  localparam logic [4:0]  HEIGHT_RESET = 5'd25;
  // Blank cell with the reset colors, used by the power-on clearing pass.
  localparam logic [15:0] INIT_CELL   = 16'h0F00;

  localparam int CFG_DATA_W = 7;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  char_code;
    logic [10:0] read_addr;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_cell;
    logic [4:0]  cursor_row_out;
    logic [6:0]  cursor_col_out;
  } out_item_t;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  ch;
    logic        do_write;
    logic        scroll;
    logic [4:0]  wr_row;
    logic [6:0]  wr_col;
    logic [10:0] rd_addr;
    logic [4:0]  cur_row;
    logic [6:0]  cur_col;
  } cmd_t;

  // Effective screen geometry and the blank cell for the current colors.
  typedef struct packed {
    logic [15:0] blank;
    logic [6:0]  width;
    logic [4:0]  height;
  } geom_t;

endpackage

>>> sv/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/tcw_queue.sv
// ----------------------------------------------------------------------------
// tcw_queue
// Short command queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module tcw_queue import tcw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  localparam int PTR_W = (TCW_QUEUE_DEPTH > 1) ? $clog2(TCW_QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TCW_QUEUE_DEPTH + 1);

  cmd_t             slots [TCW_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(TCW_QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(TCW_QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(TCW_QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`include "text_console_writer_assert.svh"

  `TCW_ASSERT_IMP(a_no_push_full, clk, rst, full, !push)
  `TCW_ASSERT_IMP(a_no_pop_empty, clk, rst, empty, !pop)
  `TCW_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(TCW_QUEUE_DEPTH))

endmodule

>>> sv/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// Holds the configuration and the cursor, accepts items and classifies them.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; #(
  parameter int MAX_COLS = TCW_MAX_COLS,
  parameter int MAX_ROWS = TCW_MAX_ROWS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  init_busy,
  input  logic                  q_full,
  output logic                  q_push,
  output cmd_t                  q_data,
  output geom_t                 geom
);

  // The width and height registers cannot exceed their field ranges anyway.
  localparam int MaxW = (MAX_COLS < 127) ? MAX_COLS : 127;
  localparam int MaxH = (MAX_ROWS < 31) ? MAX_ROWS : 31;

  logic [3:0] fg_color;
  logic [3:0] bg_color;
  logic [6:0] screen_width;
  logic [4:0] screen_height;
  logic [4:0] cursor_row;
  logic [6:0] cursor_col;

  logic [6:0] eff_w;
  logic [4:0] eff_h;
  logic [4:0] row_s;
  logic [6:0] col_s;
  logic [5:0] row_a;
  logic [7:0] col_a;
  logic [5:0] row_b;
  logic [7:0] col_b;
  logic       scroll;
  logic [5:0] row_c;
  logic       is_nl;

  always_comb begin
    if (screen_width == '0) begin
      eff_w = 7'd1;
    end else if (int'(screen_width) > MaxW) begin
      eff_w = 7'(MaxW);
    end else begin
      eff_w = screen_width;
    end
    if (screen_height == '0) begin
      eff_h = 5'd1;
    end else if (int'(screen_height) > MaxH) begin
      eff_h = 5'(MaxH);
    end else begin
      eff_h = screen_height;
    end
  end

  assign geom.blank  = {bg_color, fg_color, 8'h00};
  assign geom.width  = eff_w;
  assign geom.height = eff_h;

  // Cursor step of a put: clamp into the screen, advance, wrap and scroll.
  always_comb begin
    row_s = (cursor_row > eff_h - 5'd1) ? eff_h - 5'd1 : cursor_row;
    col_s = (cursor_col > eff_w - 7'd1) ? eff_w - 7'd1 : cursor_col;
    is_nl = (in_data.char_code == NL_CODE);
    if (is_nl) begin
      row_a = {1'b0, row_s} + 6'd1;
      col_a = '0;
    end else begin
      row_a = {1'b0, row_s};
      col_a = {1'b0, col_s} + 8'd1;
    end
    if (col_a >= {1'b0, eff_w}) begin
      row_b = row_a + 6'd1;
      col_b = '0;
    end else begin
      row_b = row_a;
      col_b = col_a;
    end
    scroll = (row_b >= {1'b0, eff_h});
    row_c  = scroll ? row_b - 6'd1 : row_b;
  end

  assign in_ready = !init_busy && !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_data          = '0;
    q_data.op       = in_data.opcode;
    q_data.ch       = in_data.char_code;
    q_data.rd_addr  = in_data.read_addr;
    q_data.wr_row   = row_s;
    q_data.wr_col   = col_s;
    q_data.cur_row  = cursor_row;
    q_data.cur_col  = cursor_col;
    if (in_data.opcode == OP_PUT) begin
      q_data.do_write = !is_nl;
      q_data.scroll   = scroll;
      q_data.cur_row  = row_c[4:0];
      q_data.cur_col  = col_b[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color      <= FG_RESET;
      bg_color      <= BG_RESET;
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
      cursor_row    <= '0;
      cursor_col    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FG:     fg_color      <= cfg_data[3:0];
          REG_BG:     bg_color      <= cfg_data[3:0];
          REG_WIDTH:  screen_width  <= cfg_data[6:0];
          REG_HEIGHT: screen_height <= cfg_data[4:0];
          default:    ;
        endcase
      end
      if (q_push && in_data.opcode == OP_PUT) begin
        cursor_row <= row_c[4:0];
        cursor_col <= col_b[6:0];
      end
    end
  end

endmodule

>>> sv/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// Carries out queued commands on the cell buffer and returns the results.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; #(
  parameter int MAX_COLS = TCW_MAX_COLS,
  parameter int MAX_ROWS = TCW_MAX_ROWS
) (
  input  logic      clk,
  input  logic      rst,
  input  geom_t     geom,
  input  logic      q_empty,
  input  cmd_t      q_data,
  output logic      q_pop,
  output logic      init_busy,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int CNT_W      = $clog2(CELL_COUNT + 1);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_COPY   = 3'd3;
  localparam logic [2:0] S_FILL   = 3'd4;
  localparam logic [2:0] S_RDWAIT = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]        state;
  cmd_t              cur;
  logic [ADDR_W-1:0] init_idx;
  logic [CNT_W-1:0]  rd_idx;
  logic [CNT_W-1:0]  copy_cnt;
  logic [CNT_W-1:0]  fill_idx;
  logic [CNT_W-1:0]  fill_end;
  logic              pend;
  logic [CNT_W-1:0]  pend_addr;
  logic [15:0]       res_cell;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [15:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [15:0]       ram_rdata;

  logic [11:0]       put_addr;
  logic [11:0]       area_wh;
  logic [11:0]       area_copy;
  logic              issuing;
  logic              rd_in_range;
  logic              out_load;

  assign put_addr    = 12'(cur.wr_row) * 12'(geom.width) + 12'(cur.wr_col);
  assign area_wh     = 12'(geom.width) * 12'(geom.height);
  assign area_copy   = 12'(geom.width) * 12'(geom.height - 5'd1);
  assign issuing     = (rd_idx < copy_cnt);
  assign rd_in_range = (int'(cur.rd_addr) < CELL_COUNT);

  assign init_busy = (state == S_INIT);
  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign out_load  = (state == S_DONE) && (!out_valid || out_ready);

  // Single write port and single read port, shared by all sequencer states.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = init_idx;
    ram_wdata = INIT_CELL;
    ram_raddr = ADDR_W'(cur.rd_addr);
    case (state)
      S_INIT: begin
        ram_we = 1'b1;
      end
      S_EXEC: begin
        ram_we    = (cur.op == OP_PUT) && cur.do_write;
        ram_waddr = ADDR_W'(put_addr);
        ram_wdata = {geom.blank[15:8], cur.ch};
      end
      S_COPY: begin
        // Reads run one row ahead of the writes that move the data up.
        ram_raddr = ADDR_W'(rd_idx + CNT_W'(geom.width));
        ram_we    = pend;
        ram_waddr = pend_addr[ADDR_W-1:0];
        ram_wdata = ram_rdata;
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_idx[ADDR_W-1:0];
        ram_wdata = geom.blank;
      end
      default: ;
    endcase
  end

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_idx  <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          init_idx <= init_idx + 1'b1;
          if (init_idx == ADDR_W'(CELL_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          pend <= 1'b0;
          case (cur.op)
            OP_PUT:   state <= cur.scroll ? S_COPY : S_DONE;
            OP_CLEAR: state <= S_FILL;
            OP_READ:  state <= S_RDWAIT;
            default:  state <= S_DONE;
          endcase
        end
        S_COPY: begin
          pend <= issuing;
          if (!issuing && !pend) begin
            state <= S_FILL;
          end
        end
        S_FILL: begin
          if (fill_idx == fill_end - 1'b1) begin
            state <= S_DONE;
          end
        end
        S_RDWAIT: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur      <= q_data;
        res_cell <= '0;
      end
      S_EXEC: begin
        rd_idx   <= '0;
        copy_cnt <= CNT_W'(area_copy);
        fill_end <= CNT_W'(area_wh);
        fill_idx <= '0;
      end
      S_COPY: begin
        pend_addr <= rd_idx;
        if (issuing) begin
          rd_idx <= rd_idx + 1'b1;
        end
        if (!issuing && !pend) begin
          fill_idx <= copy_cnt;
        end
      end
      S_FILL: begin
        fill_idx <= fill_idx + 1'b1;
      end
      S_RDWAIT: begin
        res_cell <= rd_in_range ? ram_rdata : 16'h0000;
      end
      default: ;
    endcase
    if (out_load) begin
      out_data.read_cell      <= res_cell;
      out_data.cursor_row_out <= cur.cur_row;
      out_data.cursor_col_out <= cur.cur_col;
    end
  end

`include "text_console_writer_assert.svh"

  `TCW_ASSERT_IMP(a_fill_bound, clk, rst, state == S_FILL, fill_idx < fill_end)
  `TCW_ASSERT_IMP(a_copy_trails, clk, rst, (state == S_COPY) && pend,
                  pend_addr < rd_idx + CNT_W'(geom.width))
  `TCW_ASSERT_NXT(a_done_holds, clk, rst,
                  (state == S_DONE) && out_valid && !out_ready, state == S_DONE)
  `TCW_ASSERT_IMP(a_init_no_pop, clk, rst, state == S_INIT, !q_pop && !out_valid)

endmodule

>>> sv/text_console_writer.sv
// A scrolling put also moves the screen up one row and blanks the last row; a clear
// blanks the whole screen, and a read waits for the cell read.
// The back sequencer carries out one command at a time on its single cell buffer port;
// a queue of two commands lets the input run ahead of it.
// Reset: synchronous; the cell buffer is then cleared to 0x0F00 in a pass over all
// MAX_COLS*MAX_ROWS cells (2000 by default) during which in_ready stays low.
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console buffer with put-character, clear and cell-read commands.
// ----------------------------------------------------------------------------
module text_console_writer import tcw_pkg::*; #(
  parameter int MAX_COLS = TCW_MAX_COLS,
  parameter int MAX_ROWS = TCW_MAX_ROWS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  logic  init_busy;
  logic  q_full;
  logic  q_empty;
  logic  q_push;
  logic  q_pop;
  cmd_t  q_in;
  cmd_t  q_out;
  geom_t geom;

  tcw_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .init_busy (init_busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in),
    .geom      (geom)
  );

  tcw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  tcw_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> bench/text_console_writer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_tb
// Self-checking bench for the text console writer. A short scripted run covers
// the reset screen, every opcode, out-of-range reads, wrapping, scrolling and
// clamped geometry. Random phases follow, each with its own colors and screen
// size. Results are checked against a screen model kept in the bench, or against the
// values given in the script for the checked script rows.
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 4;
  localparam int CELL_TOTAL     = TCW_MAX_COLS * TCW_MAX_ROWS;
  localparam int ADDR_TOP       = 2047;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 75;
  localparam int HOLD_CYCLES    = 80;
  localparam int MAX_GAP        = 5;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    bit         is_reg;
    logic [1:0] reg_idx;
    logic [6:0] reg_val;
    in_item_t   item;
    bit         typed;
    out_item_t  want;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;

  // Screen model and its registers.
  logic [15:0] screen [CELL_TOTAL];
  int          cur_row;
  int          cur_col;
  logic [3:0]  fg_reg;
  logic [3:0]  bg_reg;
  logic [6:0]  width_reg;
  logic [4:0]  height_reg;

  out_item_t   awaited[$];
  script_row_t script[$];
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  bit          quiet_phase = 1'b0;
  bit          hold_off_req = 1'b0;

  text_console_writer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int screen_cols();
    if (width_reg == 0) return 1;
    if (width_reg > TCW_MAX_COLS) return TCW_MAX_COLS;
    return int'(width_reg);
  endfunction

  function automatic int screen_rows();
    if (height_reg == 0) return 1;
    if (height_reg > TCW_MAX_ROWS) return TCW_MAX_ROWS;
    return int'(height_reg);
  endfunction

  // Applies one item to the screen model and returns the report it yields.
  function automatic out_item_t console_apply(in_item_t it);
    int          w;
    int          h;
    int          i;
    logic [15:0] blank;
    out_item_t   r;
    w = screen_cols();
    h = screen_rows();
    blank = {bg_reg, fg_reg, 8'h00};
    r = '0;
    case (it.opcode)
      OP_PUT: begin
        // A shrunken screen can leave the cursor outside; pull it back first.
        if (cur_row > h - 1) cur_row = h - 1;
        if (cur_col > w - 1) cur_col = w - 1;
        if (it.char_code == NL_CODE) begin
          cur_row++;
          cur_col = 0;
        end else begin
          screen[cur_row * w + cur_col] = blank | {8'h00, it.char_code};
          cur_col++;
        end
        if (cur_col >= w) begin
          cur_row++;
          cur_col = 0;
        end
        if (cur_row >= h) begin
          for (i = 0; i + w < w * h; i++) screen[i] = screen[i + w];
          for (i = (h - 1) * w; i < h * w; i++) screen[i] = blank;
          cur_row--;
        end
      end
      OP_CLEAR: begin
        for (i = 0; i < w * h; i++) screen[i] = blank;
      end
      OP_READ: begin
        if (it.read_addr < CELL_TOTAL) r.read_cell = screen[it.read_addr];
      end
      default: ;
    endcase
    r.cursor_row_out = cur_row[4:0];
    r.cursor_col_out = cur_col[6:0];
    return r;
  endfunction

  function automatic in_item_t random_item(int nl_pct);
    in_item_t it;
    int       pick;
    int       area;
    area = screen_cols() * screen_rows();
    it.opcode    = OP_PUT;
    it.char_code = 8'($urandom_range(0, 255));
    it.read_addr = 11'($urandom_range(0, ADDR_TOP));
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      if ($urandom_range(0, 99) < nl_pct) it.char_code = NL_CODE;
    end else if (pick < 84) begin
      it.opcode = OP_READ;
      // Most reads land inside the visible area, the rest anywhere.
      if ($urandom_range(0, 3) != 0) it.read_addr = 11'($urandom_range(0, area - 1));
    end else if (pick < 90) begin
      it.opcode = OP_CLEAR;
    end else begin
      it.opcode = OP_UNUSED;
    end
    return it;
  endfunction

  task automatic add_reg(input logic [1:0] idx, input logic [6:0] val);
    script_row_t row;
    row = '{default: '0};
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    script.push_back(row);
  endtask

  task automatic add_item(input logic [1:0] op, input logic [7:0] ch,
                          input logic [10:0] addr);
    script_row_t row;
    row = '{default: '0};
    row.item = '{opcode: op, char_code: ch, read_addr: addr};
    script.push_back(row);
  endtask

  task automatic add_checked(input logic [1:0] op, input logic [7:0] ch,
                             input logic [10:0] addr, input logic [15:0] cell_val,
                             input logic [4:0] row_no, input logic [6:0] col_no);
    script_row_t row;
    row = '{default: '0};
    row.item  = '{opcode: op, char_code: ch, read_addr: addr};
    row.typed = 1'b1;
    row.want  = '{read_cell: cell_val, cursor_row_out: row_no, cursor_col_out: col_no};
    script.push_back(row);
  endtask

  // Writes one register once the block has returned every result.
  task automatic set_reg(input logic [1:0] idx, input logic [6:0] val);
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_FG:     fg_reg = val[3:0];
      REG_BG:     bg_reg = val[3:0];
      REG_WIDTH:  width_reg = val;
      REG_HEIGHT: height_reg = val[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic push_item(input in_item_t it, input bit typed, input out_item_t want);
    int        gap;
    out_item_t predicted;
    gap = quiet_phase ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predicted = console_apply(it);
    awaited.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off so the input backs up.
  initial begin
    int        stall;
    out_item_t want;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = quiet_phase ? 0 : $urandom_range(0, MAX_GAP);
      if (hold_off_req) begin
        stall += HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (awaited.size() == 0) begin
        $error("unexpected result: read_cell %h row %0d col %0d",
               out_data.read_cell, out_data.cursor_row_out, out_data.cursor_col_out);
        mismatch_count++;
      end else begin
        want = awaited.pop_front();
        if (out_data.read_cell !== want.read_cell) begin
          $error("read_cell: expected %h, got %h", want.read_cell, out_data.read_cell);
          mismatch_count++;
        end
        if (out_data.cursor_row_out !== want.cursor_row_out) begin
          $error("cursor_row_out: expected %0d, got %0d",
                 want.cursor_row_out, out_data.cursor_row_out);
          mismatch_count++;
        end
        if (out_data.cursor_col_out !== want.cursor_col_out) begin
          $error("cursor_col_out: expected %0d, got %0d",
                 want.cursor_col_out, out_data.cursor_col_out);
          mismatch_count++;
        end
      end
      @(negedge clk);
    end
  end

  // Ends the run when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int nl_pct;
    int cols;
    int rows;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    for (int i = 0; i < CELL_TOTAL; i++) screen[i] = INIT_CELL;
    cur_row    = 0;
    cur_col    = 0;
    fg_reg     = FG_RESET;
    bg_reg     = BG_RESET;
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;

    // Reset screen, every opcode, reads past the buffer, newline and clear.
    add_checked(OP_READ, 8'h00, 11'd0, 16'h0F00, 5'd0, 7'd0);
    add_checked(OP_READ, 8'hFF, 11'd2047, 16'h0000, 5'd0, 7'd0);
    add_checked(OP_READ, 8'h00, 11'd1999, 16'h0F00, 5'd0, 7'd0);
    add_checked(OP_PUT, 8'h41, 11'd0, 16'h0000, 5'd0, 7'd1);
    add_checked(OP_PUT, 8'hFF, 11'd2047, 16'h0000, 5'd0, 7'd2);
    add_checked(OP_PUT, 8'h00, 11'd0, 16'h0000, 5'd0, 7'd3);
    add_checked(OP_READ, 8'h00, 11'd1, 16'h0FFF, 5'd0, 7'd3);
    add_checked(OP_UNUSED, 8'hFF, 11'd2047, 16'h0000, 5'd0, 7'd3);
    add_checked(OP_PUT, NL_CODE, 11'd0, 16'h0000, 5'd1, 7'd0);
    add_checked(OP_READ, 8'h00, 11'd0, 16'h0F41, 5'd1, 7'd0);
    add_checked(OP_CLEAR, 8'h00, 11'd0, 16'h0000, 5'd1, 7'd0);
    add_checked(OP_READ, 8'h00, 11'd0, 16'h0F00, 5'd1, 7'd0);
    // Tiny screen with inverted colors: wrap at the last column, then scroll.
    add_reg(REG_FG, 7'd0);
    add_reg(REG_BG, 7'd15);
    add_reg(REG_WIDTH, 7'd4);
    add_reg(REG_HEIGHT, 7'd2);
    add_item(OP_PUT, 8'h61, 11'd0);
    add_item(OP_PUT, 8'h62, 11'd0);
    add_item(OP_PUT, 8'h63, 11'd0);
    add_item(OP_PUT, 8'h64, 11'd0);
    add_item(OP_READ, 8'h00, 11'd0);
    add_item(OP_READ, 8'h00, 11'd4);
    // Zero width and height clamp to one cell; the cursor is pulled inside.
    add_reg(REG_WIDTH, 7'd0);
    add_reg(REG_HEIGHT, 7'd0);
    add_item(OP_PUT, 8'h7E, 11'd0);
    add_item(OP_READ, 8'h00, 11'd0);
    // Oversized values clamp to the full screen.
    add_reg(REG_WIDTH, 7'd127);
    add_reg(REG_HEIGHT, 7'd31);
    add_reg(REG_FG, 7'd15);
    add_reg(REG_BG, 7'd0);
    add_item(OP_READ, 8'h00, 11'd0);
    add_item(OP_PUT, NL_CODE, 11'd0);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[k]) begin
      if (script[k].is_reg) set_reg(script[k].reg_idx, script[k].reg_val);
      else push_item(script[k].item, script[k].typed, script[k].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      cols   = $urandom_range(1, 12);
      rows   = $urandom_range(1, 6);
      nl_pct = 15;
      if (ph == 2) begin
        cols   = TCW_MAX_COLS;
        rows   = TCW_MAX_ROWS;
        nl_pct = 4;
      end else if (ph == 4) begin
        cols   = $urandom_range(81, 127);
        rows   = $urandom_range(26, 31);
        nl_pct = 4;
      end
      set_reg(REG_FG, 7'($urandom_range(0, 15)));
      set_reg(REG_BG, 7'($urandom_range(0, 15)));
      set_reg(REG_WIDTH, 7'(cols));
      set_reg(REG_HEIGHT, 7'(rows));
      quiet_phase  = (ph == 0) || (ph == 3);
      hold_off_req = (ph == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) push_item(random_item(nl_pct), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
